// File: hdl/ws2812_spi_symbol_encoder_defines.svh
// Assertion macros used by the checker file of the LED symbol encoder.
`ifndef WS2812_SPI_SYMBOL_ENCODER_DEFINES_SVH
`define WS2812_SPI_SYMBOL_ENCODER_DEFINES_SVH

// Checks a property on the rising clock edge while reset is released.
`define WSENC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define WSENC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: hdl/wsenc_pkg.sv
// Package with the shared constants and the symbol encoding function of the LED encoder.
`default_nettype none

package wsenc_pkg;

    localparam int unsigned COLOR_W       = 8;
    localparam int unsigned BRIGHT_W      = 7;
    localparam int unsigned SYM_W         = 3;
    localparam int unsigned SPI_WORD_W    = COLOR_W * SYM_W;
    localparam int unsigned PROD_W        = COLOR_W + BRIGHT_W;
    localparam int unsigned RECIP_W       = 13;
    localparam int unsigned RECIP_SHIFT   = 19;
    localparam int unsigned QUOT_W        = PROD_W + RECIP_W;
    localparam int unsigned WORDS_PER_LED = 3;
    localparam int unsigned RESET_SLOTS_DEF = 5;

    localparam logic [SYM_W-1:0]    SYM_ONE      = 3'b110;
    localparam logic [SYM_W-1:0]    SYM_ZERO     = 3'b100;
    localparam logic [BRIGHT_W-1:0] PERCENT_FULL = 7'd100;
    // Multiplying by this value and shifting right by RECIP_SHIFT divides by one hundred
    // exactly for every product of a color byte and a percentage.
    localparam logic [RECIP_W-1:0]  RECIP_100    = 13'd5243;

    function automatic logic [SPI_WORD_W-1:0] encode_byte(input logic [COLOR_W-1:0] value);
        logic [SPI_WORD_W-1:0] word;
        word = '0;
        for (int i = 0; i < COLOR_W; i++) begin
            word[i*SYM_W +: SYM_W] = value[i] ? SYM_ONE : SYM_ZERO;
        end
        return word;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ws2812_spi_symbol_encoder.sv
// Top level of the LED color to SPI symbol encoder.
`default_nettype none

// One transfer on the s_ channel carries one LED color and a last-LED flag. Each channel is
// scaled by the brightness percentage (clamped to 100) and each bit, most significant first,
// becomes a three-bit symbol, 110 for one and 100 for zero. Three 24-bit words leave on the m_
// channel in green, red, blue order; after the last LED follow 3 * RESET_SLOTS all-zero gap
// words, the final one marked with m_frame_end. An LED takes three register stages (scale,
// divide by one hundred, encode) and then an output stage that sends one word per cycle
// while m_ready is high: three words per LED, plus 3 * RESET_SLOTS gap words after the last LED.
// The output stage is the limit; while it sends, the stages before it accept LEDs until all are full.
// Brightness writes on the cfg_ channel are always accepted and should be made while idle.
module ws2812_spi_symbol_encoder #(
    parameter int unsigned RESET_SLOTS = wsenc_pkg::RESET_SLOTS_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,

    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [wsenc_pkg::BRIGHT_W-1:0]        cfg_brightness_percent,

    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [wsenc_pkg::COLOR_W-1:0]         s_green,
    input  wire logic [wsenc_pkg::COLOR_W-1:0]         s_red,
    input  wire logic [wsenc_pkg::COLOR_W-1:0]         s_blue,
    input  wire logic                                  s_last_led,

    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [wsenc_pkg::SPI_WORD_W-1:0]           m_spi_symbols,
    output logic                                       m_is_reset_gap,
    output logic                                       m_frame_end
);

    localparam int unsigned NCH        = wsenc_pkg::WORDS_PER_LED;
    localparam int unsigned WORDS_LAST = NCH + NCH * RESET_SLOTS;
    localparam int unsigned CNT_W      = $clog2(WORDS_LAST);

    logic [wsenc_pkg::BRIGHT_W-1:0] bright_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, ser_valid_reg;
    logic s1_last_reg, s2_last_reg, s3_last_reg, ser_last_reg;

    logic [wsenc_pkg::PROD_W-1:0]     s1_prod_reg [NCH];
    logic [wsenc_pkg::COLOR_W-1:0]    s2_scaled_reg [NCH];
    logic [wsenc_pkg::SPI_WORD_W-1:0] s3_word_reg [NCH];
    logic [wsenc_pkg::SPI_WORD_W-1:0] ser_word_reg [NCH];
    logic [CNT_W-1:0]                 ser_idx_reg, ser_idx_next;

    logic [wsenc_pkg::COLOR_W-1:0] in_color [NCH];
    logic [wsenc_pkg::QUOT_W-1:0]  quot [NCH];
    logic [CNT_W-1:0]              ser_last_idx;
    logic                          ser_done, ser_load, s3_adv, s2_adv, s1_adv;

    assign cfg_ready = 1'b1;

    assign in_color[0] = s_green;
    assign in_color[1] = s_red;
    assign in_color[2] = s_blue;

    assign ser_last_idx = ser_last_reg ? CNT_W'(WORDS_LAST - 1) : CNT_W'(NCH - 1);
    assign ser_done     = ser_valid_reg && m_ready && (ser_idx_reg == ser_last_idx);
    assign ser_load     = !ser_valid_reg || ser_done;
    assign s3_adv       = !s3_valid_reg || ser_load;
    assign s2_adv       = !s2_valid_reg || s3_adv;
    assign s1_adv       = !s1_valid_reg || s2_adv;
    assign s_ready      = s1_adv;

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            quot[i] = wsenc_pkg::QUOT_W'(s1_prod_reg[i]) * wsenc_pkg::QUOT_W'(wsenc_pkg::RECIP_100);
        end
    end

    always_comb begin
        ser_idx_next = ser_idx_reg;
        if (ser_load) begin
            ser_idx_next = '0;
        end else if (m_ready) begin
            ser_idx_next = ser_idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg    <= wsenc_pkg::PERCENT_FULL;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            ser_valid_reg <= 1'b0;
            ser_idx_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                bright_reg <= (cfg_brightness_percent > wsenc_pkg::PERCENT_FULL)
                              ? wsenc_pkg::PERCENT_FULL : cfg_brightness_percent;
            end
            if (s1_adv) begin
                s1_valid_reg <= s_valid;
            end
            if (s2_adv) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (ser_load) begin
                ser_valid_reg <= s3_valid_reg;
            end
            ser_idx_reg <= ser_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            s1_last_reg <= s_last_led;
            for (int i = 0; i < NCH; i++) begin
                s1_prod_reg[i] <= wsenc_pkg::PROD_W'(in_color[i]) * wsenc_pkg::PROD_W'(bright_reg);
            end
        end
        if (s2_adv) begin
            s2_last_reg <= s1_last_reg;
            for (int i = 0; i < NCH; i++) begin
                s2_scaled_reg[i] <= quot[i][wsenc_pkg::RECIP_SHIFT +: wsenc_pkg::COLOR_W];
            end
        end
        if (s3_adv) begin
            s3_last_reg <= s2_last_reg;
            for (int i = 0; i < NCH; i++) begin
                s3_word_reg[i] <= wsenc_pkg::encode_byte(s2_scaled_reg[i]);
            end
        end
        if (ser_load) begin
            ser_last_reg <= s3_last_reg;
            for (int i = 0; i < NCH; i++) begin
                ser_word_reg[i] <= s3_word_reg[i];
            end
        end
    end

    assign m_valid        = ser_valid_reg;
    assign m_is_reset_gap = (ser_idx_reg >= CNT_W'(NCH));
    assign m_spi_symbols  = m_is_reset_gap ? '0 : ser_word_reg[ser_idx_reg[1:0]];
    assign m_frame_end    = (ser_idx_reg == CNT_W'(WORDS_LAST - 1));

endmodule

`default_nettype wire

// File: hdl/wsenc_checker.sv
// Port checker of the LED symbol encoder and its bind to the top level.
`default_nettype none

`include "ws2812_spi_symbol_encoder_defines.svh"

module wsenc_checker (
    input wire logic                                 aclk,
    input wire logic                                 aresetn,
    input wire logic                                 m_valid,
    input wire logic                                 m_ready,
    input wire logic [wsenc_pkg::SPI_WORD_W-1:0]     m_spi_symbols,
    input wire logic                                 m_is_reset_gap,
    input wire logic                                 m_frame_end
);

    // A stalled result transfer keeps its word.
    `WSENC_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_spi_symbols), "m_spi_symbols changed while stalled")
    `WSENC_ASSERT(a_gap_zero, m_valid && m_is_reset_gap |-> m_spi_symbols == 24'd0, "reset gap word is not zero")
    `WSENC_ASSERT(a_end_in_gap, m_valid && m_frame_end |-> m_is_reset_gap, "frame end outside the reset gap")
    `WSENC_ASSERT(a_symbol_form, m_valid && !m_is_reset_gap |-> (m_spi_symbols & 24'o55555555) == 24'o44444444, "color word holds a malformed symbol")
    `WSENC_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid, "result valid right after reset")

endmodule

bind ws2812_spi_symbol_encoder wsenc_checker u_wsenc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_spi_symbols  (m_spi_symbols),
    .m_is_reset_gap (m_is_reset_gap),
    .m_frame_end    (m_frame_end)
);

`default_nettype wire
